### rtl/core/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// Used by adsr_serial_mul, adsr_div127 and adsr_envelope_generator; depends on nothing.
package adsr_pkg;

   localparam int LEVEL_FRAC_BITS = 24;
   localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;   // Q1.24 level
   localparam int FACTOR_W        = 24;                    // Q0.24 factors
   localparam int VEL_W           = 7;
   localparam int SUS_W           = 7;
   localparam int CSR_DATA_W      = 25;
   localparam int CSR_INDEX_W     = 2;
   localparam int KIND_W          = 2;
   localparam int STEP_CNT_W      = 5;                     // up to 24 multiply steps
   localparam int PROD_W          = LEVEL_W + VEL_W;       // level * velocity
   localparam int DIV_CNT_W       = 5;                     // 32 quotient bits

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
   localparam logic [LEVEL_W-1:0] LEVEL_THR =
      LEVEL_W'(((64'd1 << LEVEL_FRAC_BITS) + 64'd500) / 64'd1000);

   localparam logic [VEL_W:0]          DIVISOR     = 8'd127;
   localparam logic [STEP_CNT_W-1:0]   FACTOR_STEPS = STEP_CNT_W'(FACTOR_W);
   localparam logic [STEP_CNT_W-1:0]   VEL_STEPS    = STEP_CNT_W'(VEL_W);

   // register indexes on the write port
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_FACTOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_FACTOR = 2'd3;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL_WAIT,
      ST_VOL_GO,
      ST_VOL_WAIT,
      ST_DIV_WAIT,
      ST_HOLD
   } state_type;

   // sustain level in 127ths of full scale: s * 2^24 / 127, with
   // 2^24 = 127 * 132104 + 8, so the remainder part is floor(8s / 127)
   function automatic logic [LEVEL_W-1:0] sustain_of(input logic [SUS_W-1:0] s);
      logic [LEVEL_W-1:0] s_w;
      logic [9:0]         x;
      logic [10:0]        t;
      s_w = LEVEL_W'(s);
      x   = {s, 3'b000};
      t   = 11'(x) + 11'(x >> 7) + 11'd1;
      return (s_w << 17) + (s_w << 10) + (s_w << 3) + LEVEL_W'(t[10:7]);
   endfunction

endpackage

### rtl/core/adsr_serial_mul.sv
// Bit-serial shift-add multiplier, multiplier bits taken LSB first.
// Depends on adsr_pkg.
module adsr_serial_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [adsr_pkg::LEVEL_W-1:0]           mcand,
   input  logic [adsr_pkg::FACTOR_W-1:0]          mplier,
   input  logic [adsr_pkg::STEP_CNT_W-1:0]        steps,
   output logic                                   done,
   output logic [adsr_pkg::LEVEL_W-1:0]           prod_hi,
   output logic [adsr_pkg::FACTOR_W-1:0]          prod_lo
);
   import adsr_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]      mcand_ff, mcand_in;
   logic [LEVEL_W-1:0]      acc_ff, acc_in;
   logic [FACTOR_W-1:0]     mr_ff, mr_in;
   logic [LEVEL_W:0]        sum;

   // after n steps the product is {acc, top n bits of the multiplier register}
   always_comb begin
      sum      = (LEVEL_W+1)'(acc_ff) + (mr_ff[0] ? (LEVEL_W+1)'(mcand_ff) : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      mr_in    = mr_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = steps - STEP_CNT_W'(1);
         mcand_in = mcand;
         acc_in   = '0;
         mr_in    = mplier;
      end else if (busy_ff) begin
         acc_in = sum[LEVEL_W:1];
         mr_in  = {sum[0], mr_ff[FACTOR_W-1:1]};
         cnt_in = cnt_ff - STEP_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      mr_ff    <= mr_in;
   end

   assign done    = done_ff;
   assign prod_hi = acc_ff;
   assign prod_lo = mr_ff;

endmodule

### rtl/core/adsr_div127.sv
// Restoring divider by 127, one quotient bit per cycle, MSB first.
// Depends on adsr_pkg.
module adsr_div127 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [adsr_pkg::PROD_W-1:0]   dividend,
   output logic                          done,
   output logic [adsr_pkg::PROD_W-1:0]   quotient
);
   import adsr_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]      dq_ff, dq_in;    // dividend shifts out, quotient shifts in
   logic [VEL_W-1:0]       rem_ff, rem_in;
   logic [VEL_W:0]         trial;
   logic                   qbit;

   always_comb begin
      trial   = {rem_ff, dq_ff[PROD_W-1]};
      qbit    = (trial >= DIVISOR);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         dq_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? VEL_W'(trial - DIVISOR) : trial[VEL_W-1:0];
         dq_in  = {dq_ff[PROD_W-2:0], qbit};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

### rtl/core/adsr_envelope_generator.sv
// ADSR envelope generator for one voice: sequencer, envelope state and result register.
// Depends on adsr_pkg, adsr_serial_mul and adsr_div127.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_type, req_velocity
//   rsp      out        rsp_valid/rsp_ready  rsp_volume
//   csr      in         csr_we (no wait)     csr_index, csr_wdata
//
// A note-on, a release or an unused kind is handled in the idle state as it is taken. A tick runs
// the serial multiplier by the factor (in decay or release with a non-zero factor), then by the
// velocity (one factor bit a cycle), then the serial divide by 127 (one quotient bit a cycle), to a
// valid volume; the block is ready for the next item in the cycle that the volume becomes valid.
// Reset is synchronous: phase goes to release, level and velocity to zero.
// A finished volume waits in the output register; a new item is taken
// meanwhile, and only a second finished volume stalls until the first is taken.
module adsr_envelope_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [adsr_pkg::KIND_W-1:0]        req_type,
   input  logic [adsr_pkg::VEL_W-1:0]         req_velocity,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [adsr_pkg::LEVEL_W-1:0]       rsp_volume,
   input  logic                               csr_we,
   input  logic [adsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [adsr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import adsr_pkg::*;

   // configuration
   logic [LEVEL_W-1:0]   attack_step_ff;
   logic [FACTOR_W-1:0]  decay_factor_ff;
   logic [FACTOR_W-1:0]  release_factor_ff;
   logic [LEVEL_W-1:0]   sus_ff;       // sustain level in Q1.24
   logic [LEVEL_W-1:0]   sus_thr_ff;   // sustain + 0.001, the decay exit point

   // envelope state
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [VEL_W-1:0]     peak_vel_ff, peak_vel_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_volume_ff, rsp_volume_in;

   // serial units
   logic                    mul_start;
   logic [FACTOR_W-1:0]     mul_mplier;
   logic [STEP_CNT_W-1:0]   mul_steps;
   logic                    mul_done;
   logic [LEVEL_W-1:0]      mul_hi;
   logic [FACTOR_W-1:0]     mul_lo;
   logic                    div_start;
   logic                    div_done;
   logic [PROD_W-1:0]       div_quot;

   logic                    req_fire;
   logic                    out_free;
   logic [LEVEL_W:0]        attack_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   adsr_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (level_ff),
      .mplier  (mul_mplier),
      .steps   (mul_steps),
      .done    (mul_done),
      .prod_hi (mul_hi),
      .prod_lo (mul_lo)
   );

   // dividend is level * velocity: high part and the seven low product bits
   adsr_div127 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mul_hi, mul_lo[FACTOR_W-1 -: VEL_W]}),
      .done     (div_done),
      .quotient (div_quot)
   );

   // configuration writes; sustain is converted to Q1.24 as it is written
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff    <= '0;
         decay_factor_ff   <= '0;
         release_factor_ff <= '0;
         sus_ff            <= '0;
         sus_thr_ff        <= LEVEL_THR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTACK_STEP:    attack_step_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_DECAY_FACTOR:   decay_factor_ff   <= csr_wdata[FACTOR_W-1:0];
            CSR_SUSTAIN_LEVEL: begin
               sus_ff     <= sustain_of(csr_wdata[SUS_W-1:0]);
               sus_thr_ff <= sustain_of(csr_wdata[SUS_W-1:0]) + LEVEL_THR;
            end
            CSR_RELEASE_FACTOR: release_factor_ff <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RELEASE;
         level_ff     <= '0;
         peak_vel_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         peak_vel_ff  <= peak_vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_volume_ff <= rsp_volume_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      level_in      = level_ff;
      peak_vel_in   = peak_vel_ff;
      rsp_volume_in = rsp_volume_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mul_start     = 1'b0;
      mul_mplier    = decay_factor_ff;
      mul_steps     = FACTOR_STEPS;
      div_start     = 1'b0;
      attack_sum    = (LEVEL_W+1)'(level_ff) + (LEVEL_W+1)'(attack_step_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_type)
                  KIND_NOTE_ON: begin
                     phase_in    = PH_ATTACK;
                     level_in    = '0;
                     peak_vel_in = req_velocity;
                  end
                  KIND_RELEASE: phase_in = PH_RELEASE;
                  KIND_TICK: begin
                     // attack: add the step; past 1.0, or with a zero step, clamp to 1.0 and move on to decay
                     if (phase_ff == PH_ATTACK) begin
                        level_in = attack_sum[LEVEL_W-1:0];
                        if (attack_sum > (LEVEL_W+1)'(LEVEL_ONE) || attack_step_ff == '0) begin
                           level_in = LEVEL_ONE;
                           phase_in = PH_DECAY;
                        end
                     end
                     state_in = ST_DECIDE;
                  end
                  default: ;   // unused kind: drop it
               endcase
            end
         end

         ST_DECIDE: begin
            case (phase_ff)
               PH_DECAY: begin
                  if (decay_factor_ff == '0) begin
                     level_in = sus_ff;
                     phase_in = PH_SUSTAIN;
                     state_in = ST_VOL_GO;
                  end else begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL_WAIT;
                  end
               end
               PH_RELEASE: begin
                  if (release_factor_ff == '0) begin
                     level_in = '0;
                     state_in = ST_VOL_GO;
                  end else begin
                     mul_start  = 1'b1;
                     mul_mplier = release_factor_ff;
                     state_in   = ST_MUL_WAIT;
                  end
               end
               default: state_in = ST_VOL_GO;   // attack at or below 1.0, or sustain: hold
            endcase
         end

         ST_MUL_WAIT: begin
            if (mul_done) begin
               level_in = mul_hi;
               if (phase_ff == PH_DECAY) begin
                  if (mul_hi < sus_thr_ff) begin
                     level_in = sus_ff;
                     phase_in = PH_SUSTAIN;
                  end
               end else if (mul_hi < LEVEL_THR) begin
                  level_in = '0;
               end
               state_in = ST_VOL_GO;
            end
         end

         ST_VOL_GO: begin
            mul_start  = 1'b1;
            mul_mplier = FACTOR_W'(peak_vel_ff);
            mul_steps  = VEL_STEPS;
            state_in   = ST_VOL_WAIT;
         end

         ST_VOL_WAIT: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end

         ST_DIV_WAIT: begin
            if (div_done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_volume_in = div_quot[LEVEL_W-1:0];
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end

         ST_HOLD: begin
            // quotient stays in the divider until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_volume_in = div_quot[LEVEL_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_volume = rsp_volume_ff;

endmodule

### verif/tb_adsr_envelope_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ADSR envelope generator: a stimulus table, then random note phrases.
// Depends on adsr_pkg and adsr_envelope_generator; expected volumes come from a predictor here or are typed in.
module tb_adsr_envelope_generator;
   import adsr_pkg::*;

   // item kind that the block must drop without a result
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // settle time after the last expected volume; covers any item still in flight
   localparam int SETTLE_CYCLES   = 100;
   // long stall of the result side, enough to fill the block and stall its input
   localparam int HOLD_OFF_CYCLES = 600;
   // cycles with no item moving on either channel before the run is abandoned
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASES          = 7;
   localparam int PHASE_ITEMS     = 100;

   typedef enum logic [1:0] {
      ROW_WRITE,     // register write: code is the index, value the write data
      ROW_ITEM,      // item checked against the predictor
      ROW_QUOTED     // item whose volume is typed in as value
   } row_kind_type;

   typedef struct packed {
      row_kind_type           what;
      logic [KIND_W-1:0]      code;
      logic [VEL_W-1:0]       vel;
      logic [CSR_DATA_W-1:0]  value;
   } stim_row_type;

   // Directed part. Registers start at zero, so the first note gets an
   // instant attack and decay.
   localparam stim_row_type DIRECTED [0:30] = '{
      // after reset: release phase, level and velocity zero
      '{ROW_QUOTED, KIND_TICK,    7'd127, 25'd0},
      '{ROW_WRITE,  CSR_SUSTAIN_LEVEL, 7'd0, 25'd127},
      // instant attack and decay to full-scale sustain, then hold there
      '{ROW_ITEM,   KIND_NOTE_ON, 7'd127, 25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd16777216},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd16777216},
      // instant release drops straight to zero
      '{ROW_ITEM,   KIND_RELEASE, 7'd0,   25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd0},
      // unused kind: no result, no change
      '{ROW_ITEM,   KIND_UNUSED,  7'd127, 25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd0},
      // an attack step of 1.0 lands exactly on 1.0 and stays in attack
      '{ROW_WRITE,  CSR_ATTACK_STEP, 7'd0, 25'd16777216},
      '{ROW_ITEM,   KIND_NOTE_ON, 7'd127, 25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd16777216},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      // half step: 0.5, exactly 1.0, then overflow clamp into a slow decay;
      // bit 24 of the decay write lies above the register and is dropped
      '{ROW_WRITE,  CSR_ATTACK_STEP, 7'd0, 25'd8388608},
      '{ROW_WRITE,  CSR_DECAY_FACTOR, 7'd0, 25'h1FFFFFF},
      '{ROW_WRITE,  CSR_SUSTAIN_LEVEL, 7'd0, 25'd0},
      '{ROW_ITEM,   KIND_NOTE_ON, 7'd127, 25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd8388608},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd16777216},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      // release out of decay, with a factor of 0.75
      '{ROW_ITEM,   KIND_RELEASE, 7'd0,   25'd0},
      '{ROW_WRITE,  CSR_RELEASE_FACTOR, 7'd0, 25'h1C00000},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      // zero velocity silences the voice whatever the level
      '{ROW_ITEM,   KIND_NOTE_ON, 7'd0,   25'd0},
      '{ROW_QUOTED, KIND_TICK,    7'd0,   25'd0},
      // release straight out of attack
      '{ROW_ITEM,   KIND_NOTE_ON, 7'd1,   25'd0},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0},
      '{ROW_ITEM,   KIND_RELEASE, 7'd0,   25'd0},
      '{ROW_ITEM,   KIND_TICK,    7'd0,   25'd0}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [KIND_W-1:0]       req_type;
   logic [VEL_W-1:0]        req_velocity;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [LEVEL_W-1:0]      rsp_volume;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // travels with the item: a typed-in volume replaces the predicted one
   logic                    quoted_ok;
   logic [LEVEL_W-1:0]      quoted_volume;

   // predictor copy of the registers and the voice state
   logic [LEVEL_W-1:0]      env_attack;
   logic [FACTOR_W-1:0]     env_decay;
   logic [SUS_W-1:0]        env_sustain;
   logic [FACTOR_W-1:0]     env_release;
   phase_type               env_phase;
   logic [LEVEL_W-1:0]      env_level;
   logic [VEL_W-1:0]        env_velocity;
   logic [LEVEL_W-1:0]      predicted_volume;

   logic [LEVEL_W-1:0]      pending_volumes[$];
   int                      mismatch_count = 0;
   int                      counted_items  = 0;

   // shared between the sender and the receiver
   logic                    calm_stretch    = 1'b0;
   logic                    hold_off_asked  = 1'b0;
   logic                    hold_off_done   = 1'b0;

   always #5ns clock = ~clock;

   adsr_envelope_generator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_velocity (req_velocity),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_volume   (rsp_volume),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Advance the envelope by one tick and return the volume it gives.
   // Work in 64 bits: the attack sum may pass 1.0 and the factor products
   // reach 48 bits before the shift.
   function automatic logic [LEVEL_W-1:0] advance_envelope();
      logic [63:0] full;
      logic [63:0] floor_level;
      logic [63:0] sustain_at;
      logic [63:0] lvl;
      full        = 64'd1 << LEVEL_FRAC_BITS;
      floor_level = (full + 64'd500) / 64'd1000;      // 0.001, rounded
      sustain_at  = (64'(env_sustain) * full) / 64'd127;
      lvl         = 64'(env_level);
      if (env_phase == PH_ATTACK) begin
         if (env_attack != '0)
            lvl = lvl + 64'(env_attack);
         // only a level strictly above 1.0, or a zero step, leaves attack; clamp it
         if (lvl > full || env_attack == '0) begin
            lvl       = full;
            env_phase = PH_DECAY;
         end
      end
      // decay begins in the same tick that attack ends
      if (env_phase == PH_DECAY) begin
         if (env_decay != '0)
            lvl = (lvl * 64'(env_decay)) >> FACTOR_W;
         if (lvl < sustain_at + floor_level || env_decay == '0) begin
            lvl       = sustain_at;
            env_phase = PH_SUSTAIN;
         end
      end
      if (env_phase == PH_RELEASE) begin
         if (env_release != '0)
            lvl = (lvl * 64'(env_release)) >> FACTOR_W;
         if (lvl < floor_level || env_release == '0)
            lvl = '0;
      end
      env_level = LEVEL_W'(lvl);
      return LEVEL_W'((lvl * 64'(env_velocity)) / 64'd127);
   endfunction

   // Scoreboard: everything is sampled at the rising edge, before the block's
   // own updates land. Results are checked before new items are predicted;
   // no result can leave in the cycle its item arrives.
   always @(posedge clock) begin : scoreboard
      if (reset) begin
         env_attack   = '0;
         env_decay    = '0;
         env_sustain  = '0;
         env_release  = '0;
         env_phase    = PH_RELEASE;
         env_level    = '0;
         env_velocity = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_volumes.size() == 0) begin
               $error("rsp_volume: unexpected item %0d with nothing expected", rsp_volume);
               mismatch_count++;
            end else if (rsp_volume !== pending_volumes[0]) begin
               $error("rsp_volume: expected %0d, actual %0d", pending_volumes[0], rsp_volume);
               mismatch_count++;
               void'(pending_volumes.pop_front());
            end else begin
               void'(pending_volumes.pop_front());
            end
         end
         // bits above each register's width are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_ATTACK_STEP:    env_attack  = csr_wdata[LEVEL_W-1:0];
               CSR_DECAY_FACTOR:   env_decay   = csr_wdata[FACTOR_W-1:0];
               CSR_SUSTAIN_LEVEL:  env_sustain = csr_wdata[SUS_W-1:0];
               CSR_RELEASE_FACTOR: env_release = csr_wdata[FACTOR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_type)
               KIND_NOTE_ON: begin
                  env_phase    = PH_ATTACK;
                  env_level    = '0;
                  env_velocity = req_velocity;
               end
               KIND_RELEASE: env_phase = PH_RELEASE;
               KIND_TICK: begin
                  predicted_volume = advance_envelope();
                  pending_volumes.push_back(quoted_ok ? quoted_volume : predicted_volume);
               end
               default: ;
            endcase
         end
      end
   end

   // Result side: stall at random about 12 percent of the time, none during the calm
   // stretch, and hold off once for a long stretch on request.
   initial begin : receiver
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_ready <= calm_stretch || ($urandom_range(99) >= 12);
      end
   end

   // Abandon the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Offer one item and hold it until taken. Returns at the accepting edge,
   // so the caller drives the next item in that same step.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VEL_W-1:0] vel,
                            input logic quoted, input logic [LEVEL_W-1:0] volume);
      // gaps of varied length so they fall across every stage of a tick
      if (!calm_stretch && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_velocity  <= vel;
      quoted_ok     <= quoted;
      quoted_volume <= volume;
      do
         @(posedge clock);
      while (!req_ready);
      if (kind != KIND_UNUSED)
         counted_items++;
   endtask

   // Drop valid, wait for every expected volume, then let any result-free
   // item still inside the block finish.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_volumes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; csr_we drops again before the task returns, which keeps back-to-back writes apart.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] attack,
                                input logic [CSR_DATA_W-1:0] decay,
                                input logic [CSR_DATA_W-1:0] sustain,
                                input logic [CSR_DATA_W-1:0] release_f);
      wait_until_idle();
      write_register(CSR_ATTACK_STEP, attack);
      write_register(CSR_DECAY_FACTOR, decay);
      write_register(CSR_SUSTAIN_LEVEL, sustain);
      write_register(CSR_RELEASE_FACTOR, release_f);
   endtask

   // Mostly whole notes: note-on, ticks through attack and decay, release,
   // ticks through release. The rest is loose items of any kind.
   task automatic play_phrases(input int quota);
      int target;
      target = counted_items + quota;
      while (counted_items < target) begin
         if ($urandom_range(99) < 85) begin
            send_item(KIND_NOTE_ON, VEL_W'($urandom), 1'b0, '0);
            repeat ($urandom_range(1, 24))
               send_item(KIND_TICK, VEL_W'($urandom), 1'b0, '0);
            send_item(KIND_RELEASE, VEL_W'($urandom), 1'b0, '0);
            repeat ($urandom_range(1, 16))
               send_item(KIND_TICK, VEL_W'($urandom), 1'b0, '0);
         end else begin
            send_item(KIND_W'($urandom), VEL_W'($urandom), 1'b0, '0);
         end
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] attack;
      logic [CSR_DATA_W-1:0] decay;
      logic [CSR_DATA_W-1:0] release_f;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= KIND_TICK;
      req_velocity  <= '0;
      quoted_ok     <= 1'b0;
      quoted_volume <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_ATTACK_STEP;
      csr_wdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         case (DIRECTED[r].what)
            ROW_WRITE: begin
               wait_until_idle();
               write_register(DIRECTED[r].code, DIRECTED[r].value);
            end
            ROW_QUOTED:
               send_item(DIRECTED[r].code, DIRECTED[r].vel, 1'b1,
                         DIRECTED[r].value[LEVEL_W-1:0]);
            default:
               send_item(DIRECTED[r].code, DIRECTED[r].vel, 1'b0, '0);
         endcase
      end

      // Each phase runs under its own settings: all zero, attack 1.0 and the rest at their top,
      // random ones with factors slow enough to show each stage, and last any write data at all.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: load_settings('0, '0, '0, '0);
            1: load_settings(LEVEL_ONE, 25'h1FFFFFF, 25'd127, 25'h1FFFFFF);
            PHASES - 1: begin
               // attack up to 1.0, the rest anything the write port allows, bits above each register included
               attack = CSR_DATA_W'($urandom_range(1 << LEVEL_FRAC_BITS));
               load_settings(attack, CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                             CSR_DATA_W'($urandom));
            end
            default: begin
               attack    = CSR_DATA_W'($urandom_range(1 << LEVEL_FRAC_BITS)
                                       >> $urandom_range(6));
               decay     = {1'($urandom), 24'($urandom_range(24'hF80000, 24'h800000))};
               release_f = {1'($urandom), 24'($urandom_range(24'hF80000, 24'h800000))};
               load_settings(attack, decay, CSR_DATA_W'($urandom), release_f);
            end
         endcase
         // the receiver's long hold-off lands while this phase keeps offering items
         if (p == 3)
            hold_off_asked = 1'b1;
         calm_stretch = (p == 4);
         play_phrases(PHASE_ITEMS);
      end

      wait_until_idle();
      if (mismatch_count == 0 && pending_volumes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
